// ----- src/assert_macros.svh -----
// Assertion macros for the RTL that checks its own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/csht_pkg.sv -----
// Types, command and status codes, and defaults for the chained scatter hash table.
`timescale 1ns / 1ps

package csht_pkg;

  localparam int TABLE_SIZE_DEF = 64;
  localparam int ENTRY_TOTAL_W  = 7;

  localparam logic [1:0] CMD_PUT    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] lookup_key;
    logic [31:0]        data_word;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              read_value;
    logic [ENTRY_TOTAL_W-1:0] entry_total;
  } rsp_t;

endpackage

// ----- src/chained_scatter_hash_table.sv -----
// Top level: hash table with in-table collision chains, kept in one slot memory.
`timescale 1ns / 1ps
// Usage
//   in_valid/in_ready/in_data carry one request (put, get or remove of a 32-bit key).
//   out_valid/out_ready/out_data return exactly one response per request, in order:
//   status, the value found by a get, and the key count after the request.
//   A request is taken at an edge where in_valid and in_ready are both high.
// Request flow
//   One request is worked at a time. Each step reads the slot memory once
//   (one registered read port). A request passes through: accept, a visit of
//   each chain slot, a check of each slot by the free-slot scan, a walk over
//   each slot to relink a displaced key, a fetch of the successor of a removed
//   chain head, a write of each changed slot (0 to 3), and the response.
// Reset
//   rst_n low clears control state; afterwards a clearing pass writes every slot
//   to zero, with in_ready low.
// Stalls
//   The response sits in an output register; a new request is accepted while it
//   waits. A finished request holds in its response state while that response waits for out_ready.
//   TABLE_SIZE must be a power of two.
module chained_scatter_hash_table
  import csht_pkg::*;
#(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

`include "assert_macros.svh"

  localparam int IDX_W    = $clog2(TABLE_SIZE);
  localparam int CNT_W    = IDX_W + 1;
  localparam int WQ_DEPTH = 3;

  typedef struct packed {
    logic             valid;
    logic [31:0]      key;
    logic [31:0]      val;
    logic [IDX_W-1:0] link;
  } slot_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_FIND  = 8'b0000_0100,
    S_RDNX  = 8'b0000_1000,
    S_SCAN  = 8'b0001_0000,
    S_WALK  = 8'b0010_0000,
    S_WRITE = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  // Offset from slot 'from' to the successor of 'base', or end of chain.
  function automatic logic [IDX_W-1:0] relink(input logic [IDX_W-1:0] from,
                                              input logic [IDX_W-1:0] base,
                                              input logic [IDX_W-1:0] link);
    logic [IDX_W-1:0] r;
    r = (link == '0) ? '0 : base + link - from;
    return r;
  endfunction

  slot_t slot_mem [TABLE_SIZE];
  slot_t rd_data_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic [IDX_W-1:0] rd_addr;

  state_t           state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [31:0]      val_r, val_nxt;
  logic [IDX_W-1:0] node_r, node_nxt;
  logic             prev_ok_r, prev_ok_nxt;
  logic [IDX_W-1:0] prev_r, prev_nxt;
  slot_t            prev_ent_r, prev_ent_nxt;
  slot_t            home_ent_r, home_ent_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic [IDX_W-1:0] free_ptr_r, free_ptr_nxt;
  logic             pass_r, pass_nxt;
  logic [IDX_W-1:0] nx_r, nx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [31:0]      rdval_r, rdval_nxt;
  logic [IDX_W-1:0] wq_addr_r [WQ_DEPTH];
  logic [IDX_W-1:0] wq_addr_nxt [WQ_DEPTH];
  slot_t            wq_data_r [WQ_DEPTH];
  slot_t            wq_data_nxt [WQ_DEPTH];
  logic [1:0]       wq_n_r, wq_n_nxt;
  logic [IDX_W-1:0] clr_ptr_r, clr_ptr_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;

  logic [IDX_W-1:0] follow_idx;
  logic [IDX_W-1:0] home_idx;
  logic [IDX_W-1:0] old_home;
  logic [IDX_W-1:0] scan_next;
  logic             first_node;
  logic             key_eq;
  logic             hit;
  logic             miss;
  slot_t            home_ent;
  logic             walk_more;

  assign follow_idx = node_r + rd_data_r.link;
  assign home_idx   = key_r[IDX_W-1:0];
  assign old_home   = home_ent_r.key[IDX_W-1:0];
  assign scan_next  = (free_ptr_r == IDX_W'(1)) ? '1 : free_ptr_r - 1'b1;
  assign first_node = (steps_r == '0);
  assign key_eq     = (rd_data_r.key == key_r);
  assign home_ent   = first_node ? rd_data_r : home_ent_r;
  // Home slot empty ends the search at once; later slots are compared by key only.
  assign hit  = !(first_node && !rd_data_r.valid) && key_eq;
  assign miss = !hit && ((first_node && !rd_data_r.valid) || (rd_data_r.link == '0) ||
                         (steps_r == CNT_W'(TABLE_SIZE - 1)));
  assign walk_more = (follow_idx != home_idx) && (rd_data_r.link != '0) &&
                     !steps_r[CNT_W-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= slot_mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    val_nxt      = val_r;
    node_nxt     = node_r;
    prev_ok_nxt  = prev_ok_r;
    prev_nxt     = prev_r;
    prev_ent_nxt = prev_ent_r;
    home_ent_nxt = home_ent_r;
    steps_nxt    = steps_r;
    free_ptr_nxt = free_ptr_r;
    pass_nxt     = pass_r;
    nx_nxt       = nx_r;
    count_nxt    = count_r;
    status_nxt   = status_r;
    rdval_nxt    = rdval_r;
    wq_addr_nxt  = wq_addr_r;
    wq_data_nxt  = wq_data_r;
    wq_n_nxt     = wq_n_r;
    clr_ptr_nxt  = clr_ptr_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en    = 1'b0;
    wr_addr  = clr_ptr_r;
    wr_data  = '0;
    rd_addr  = follow_idx;
    in_ready = 1'b0;

    case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = in_data.lookup_key[IDX_W-1:0];
        if (in_valid) begin
          cmd_nxt     = in_data.cmd;
          key_nxt     = $unsigned(in_data.lookup_key);
          val_nxt     = in_data.data_word;
          node_nxt    = in_data.lookup_key[IDX_W-1:0];
          steps_nxt   = '0;
          prev_ok_nxt = 1'b0;
          rdval_nxt   = '0;
          status_nxt  = ST_DONE;
          if (in_data.cmd == CMD_PUT || in_data.cmd == CMD_GET ||
              in_data.cmd == CMD_REMOVE) begin
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_FIND: begin
        home_ent_nxt = home_ent;
        if (hit) begin
          case (cmd_r)
            CMD_GET: begin
              rdval_nxt = rd_data_r.val;
              state_nxt = S_RESP;
            end
            CMD_PUT: begin
              status_nxt = ST_PRESENT;
              state_nxt  = S_RESP;
            end
            CMD_REMOVE: begin
              count_nxt = count_r - 1'b1;
              if (prev_ok_r) begin
                // Unlink from the predecessor, then clear the slot.
                wq_addr_nxt[0] = prev_r;
                wq_data_nxt[0] = prev_ent_r;
                wq_data_nxt[0].link = relink(prev_r, node_r, rd_data_r.link);
                wq_addr_nxt[1] = node_r;
                wq_data_nxt[1] = '0;
                wq_n_nxt  = 2'd2;
                state_nxt = S_WRITE;
              end else if (rd_data_r.link != '0) begin
                // Head of chain with a successor: pull the successor in.
                nx_nxt    = follow_idx;
                state_nxt = S_RDNX;
              end else begin
                wq_addr_nxt[0] = node_r;
                wq_data_nxt[0] = '0;
                wq_n_nxt  = 2'd1;
                state_nxt = S_WRITE;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end else if (miss) begin
          if (cmd_r == CMD_PUT) begin
            if (!home_ent.valid) begin
              wq_addr_nxt[0] = home_idx;
              wq_data_nxt[0].valid = 1'b1;
              wq_data_nxt[0].key   = key_r;
              wq_data_nxt[0].val   = val_r;
              wq_data_nxt[0].link  = home_ent.link;
              wq_n_nxt  = 2'd1;
              count_nxt = count_r + 1'b1;
              state_nxt = S_WRITE;
            end else begin
              rd_addr   = free_ptr_r;
              pass_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
          end else begin
            status_nxt = ST_MISSING;
            state_nxt  = S_RESP;
          end
        end else begin
          prev_ok_nxt  = 1'b1;
          prev_nxt     = node_r;
          prev_ent_nxt = rd_data_r;
          node_nxt     = follow_idx;
          steps_nxt    = steps_r + 1'b1;
        end
      end

      S_RDNX: begin
        wq_addr_nxt[0] = node_r;
        wq_data_nxt[0] = rd_data_r;
        wq_data_nxt[0].link = relink(node_r, nx_r, rd_data_r.link);
        wq_addr_nxt[1] = nx_r;
        wq_data_nxt[1] = '0;
        wq_n_nxt  = 2'd2;
        state_nxt = S_WRITE;
      end

      S_SCAN: begin
        if (!rd_data_r.valid) begin
          count_nxt = count_r + 1'b1;
          if (old_home == home_idx) begin
            // Occupant belongs here: chain the new key right behind it.
            wq_addr_nxt[0] = free_ptr_r;
            wq_data_nxt[0].valid = 1'b1;
            wq_data_nxt[0].key   = key_r;
            wq_data_nxt[0].val   = val_r;
            wq_data_nxt[0].link  = relink(free_ptr_r, home_idx, home_ent_r.link);
            wq_addr_nxt[1] = home_idx;
            wq_data_nxt[1] = home_ent_r;
            wq_data_nxt[1].link = free_ptr_r - home_idx;
            wq_n_nxt  = 2'd2;
            state_nxt = S_WRITE;
          end else begin
            // Occupant is a guest: find its predecessor in its own chain.
            rd_addr   = old_home;
            node_nxt  = old_home;
            steps_nxt = '0;
            state_nxt = S_WALK;
          end
        end else begin
          rd_addr      = scan_next;
          free_ptr_nxt = scan_next;
          if (free_ptr_r == IDX_W'(1)) begin
            pass_nxt = 1'b1;
            if (pass_r) begin
              status_nxt = ST_FULL;
              state_nxt  = S_RESP;
            end
          end
        end
      end

      S_WALK: begin
        if (walk_more) begin
          node_nxt  = follow_idx;
          steps_nxt = steps_r + 1'b1;
        end else begin
          wq_addr_nxt[0] = node_r;
          wq_data_nxt[0] = rd_data_r;
          wq_data_nxt[0].link = free_ptr_r - node_r;
          wq_addr_nxt[1] = free_ptr_r;
          wq_data_nxt[1] = home_ent_r;
          wq_data_nxt[1].valid = 1'b1;
          wq_data_nxt[1].link  = relink(free_ptr_r, home_idx, home_ent_r.link);
          wq_addr_nxt[2] = home_idx;
          wq_data_nxt[2].valid = 1'b1;
          wq_data_nxt[2].key   = key_r;
          wq_data_nxt[2].val   = val_r;
          wq_data_nxt[2].link  = '0;
          wq_n_nxt  = 2'd3;
          state_nxt = S_WRITE;
        end
      end

      S_WRITE: begin
        wr_en   = 1'b1;
        wr_addr = wq_addr_r[0];
        wr_data = wq_data_r[0];
        // Advance the write list.
        for (int i = 0; i < WQ_DEPTH - 1; i++) begin
          wq_addr_nxt[i] = wq_addr_r[i+1];
          wq_data_nxt[i] = wq_data_r[i+1];
        end
        wq_n_nxt = wq_n_r - 1'b1;
        if (wq_n_r == 2'd1) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.status     = status_r;
          out_data_nxt.read_value = rdval_r;
          out_data_nxt.entry_total = ENTRY_TOTAL_W'(count_r);
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_ptr_r   <= '0;
      count_r     <= '0;
      free_ptr_r  <= '1;
      pass_r      <= 1'b0;
      wq_n_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_ptr_r   <= clr_ptr_nxt;
      count_r     <= count_nxt;
      free_ptr_r  <= free_ptr_nxt;
      pass_r      <= pass_nxt;
      wq_n_r      <= wq_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    node_r     <= node_nxt;
    prev_ok_r  <= prev_ok_nxt;
    prev_r     <= prev_nxt;
    prev_ent_r <= prev_ent_nxt;
    home_ent_r <= home_ent_nxt;
    steps_r    <= steps_nxt;
    nx_r       <= nx_nxt;
    status_r   <= status_nxt;
    rdval_r    <= rdval_nxt;
    wq_addr_r  <= wq_addr_nxt;
    wq_data_r  <= wq_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_count_range, count_r <= CNT_W'(TABLE_SIZE), "key count beyond table size")
  `ASSERT_ALWAYS(a_scan_nonzero, free_ptr_r != '0, "free-slot pointer parked on slot zero")
  `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r != S_IDLE, "accepted request dropped")
  `ASSERT_IMPLY(a_out_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP, "response not from response state")
  `ASSERT_IMPLY(a_count_step, count_r != $past(count_r), (count_r == $past(count_r) + 1'b1) || (count_r + 1'b1 == $past(count_r)), "key count jumped")

endmodule
